/* rtl/core/shae_pkg.sv */
package shae_pkg;

   localparam int BLOCK_BITS = 512;
   localparam int WORD_BITS  = 32;
   localparam int ROUNDS     = 64;

   typedef struct packed {
      logic                  final_blk;
      logic [BLOCK_BITS-1:0] data;
   } blk_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   localparam logic [31:0] K_ROUND [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] INIT_256 [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] INIT_224 [8] = '{
      32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
      32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
   };

   localparam logic ACT_APPEND = 1'b0;
   localparam logic ACT_FINISH = 1'b1;
   localparam logic MODE_224   = 1'b1;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      logic [63:0] d;
      d = {x, x} >> n;
      return d[31:0];
   endfunction

   function automatic logic [31:0] ssig0(input logic [31:0] x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] ssig1(input logic [31:0] x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic logic [31:0] bsig0(input logic [31:0] x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] bsig1(input logic [31:0] x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

endpackage

/* rtl/core/sha256_hash_engine.sv */
// append transaction: up to one byte per cycle while the block queue has room
// each 64-byte block goes through the round unit as load, 64 rounds, hash add
// finish transaction: padding, one or two block compressions, then one digest word per
// cycle while rsp_tready allows (8 for sha-256, 7 for sha-224); the next input waits for the pad
// sustained rate is set by the round unit, which is slower than the byte input
// synchronous reset loads the sha-256 initial hash, clears the count, queue and mode
module sha256_hash_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // digest_word
   output logic [2:0]  rsp_tuser,   // word_index
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   logic                   mode_ff, mode_in;
   logic                   push, pop;
   shae_pkg::blk_type      push_blk, head_blk;
   shae_pkg::q_status_type q_status;

   assign mode_in = csr_wr_en ? csr_wr_data : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
      end
   end

   shae_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_action (req_tuser),
      .in_byte   (req_tdata),
      .q_status  (q_status),
      .push      (push),
      .push_blk  (push_blk)
   );

   shae_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_blk (push_blk),
      .pop      (pop),
      .head_blk (head_blk),
      .status   (q_status)
   );

   shae_back u_back (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode_ff),
      .head_blk  (head_blk),
      .q_status  (q_status),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_word  (rsp_tdata),
      .out_index (rsp_tuser),
      .out_last  (rsp_tlast)
   );

endmodule

/* rtl/core/shae_front.sv */
module shae_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic                   in_action,
   input  logic [7:0]             in_byte,
   input  shae_pkg::q_status_type q_status,
   output logic                   push,
   output shae_pkg::blk_type      push_blk
);

   typedef enum logic [1:0] {
      ST_FILL = 2'b01,
      ST_PAD  = 2'b10
   } fstate_type;

   fstate_type                          state_ff, state_in;
   logic [5:0]                          pos_ff, pos_in;
   logic [63:0]                         count_ff, count_in;
   logic [63:0]                         len_ff, len_in;
   logic                                first_ff, first_in;
   logic                                len_blk_ff, len_blk_in;
   logic [shae_pkg::BLOCK_BITS-1:0]     buf_ff, buf_in;
   logic                                wr;
   logic [7:0]                          wr_byte;
   logic                                len_blk_now;

   assign in_ready = (state_ff == ST_FILL) && !q_status.full;

   always_comb begin
      state_in    = state_ff;
      pos_in      = pos_ff;
      count_in    = count_ff;
      len_in      = len_ff;
      first_in    = first_ff;
      len_blk_in  = len_blk_ff;
      wr          = 1'b0;
      wr_byte     = in_byte;
      len_blk_now = len_blk_ff;
      push        = 1'b0;
      push_blk.final_blk = 1'b0;
      case (state_ff)
         ST_FILL: begin
            if (in_valid && in_ready) begin
               if (in_action == shae_pkg::ACT_APPEND) begin
                  wr       = 1'b1;
                  count_in = count_ff + 64'd8;
                  if (pos_ff == 6'd63) begin
                     push = 1'b1;
                  end
               end else begin
                  state_in   = ST_PAD;
                  len_in     = count_ff;
                  count_in   = '0;
                  first_in   = 1'b1;
                  len_blk_in = 1'b0;
               end
            end
         end
         ST_PAD: begin
            if (!(pos_ff == 6'd63 && q_status.full)) begin
               wr = 1'b1;
               if (first_ff) begin
                  wr_byte     = 8'h80;
                  len_blk_now = (pos_ff < 6'd56);
                  first_in    = 1'b0;
               end else if (len_blk_ff && pos_ff >= 6'd56) begin
                  wr_byte = len_ff[63:56];
                  len_in  = {len_ff[55:0], 8'h00};
               end else begin
                  wr_byte = 8'h00;
               end
               len_blk_in = len_blk_now;
               if (pos_ff == 6'd63) begin
                  push               = 1'b1;
                  push_blk.final_blk = len_blk_now;
                  len_blk_in         = 1'b1;
                  if (len_blk_now) begin
                     state_in = ST_FILL;
                  end
               end
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
      buf_in = wr ? {buf_ff[shae_pkg::BLOCK_BITS-9:0], wr_byte} : buf_ff;
      if (wr) begin
         pos_in = pos_ff + 6'd1;
      end
      push_blk.data = buf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_FILL;
         pos_ff     <= '0;
         count_ff   <= '0;
         first_ff   <= 1'b0;
         len_blk_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pos_ff     <= pos_in;
         count_ff   <= count_in;
         first_ff   <= first_in;
         len_blk_ff <= len_blk_in;
      end
      len_ff <= len_in;
      buf_ff <= buf_in;
   end

endmodule

/* rtl/core/shae_queue.sv */
module shae_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  shae_pkg::blk_type      push_blk,
   input  logic                   pop,
   output shae_pkg::blk_type      head_blk,
   output shae_pkg::q_status_type status
);

   shae_pkg::blk_type entry_ff [2];
   logic              wp_ff, wp_in;
   logic              rp_ff, rp_in;
   logic [1:0]        cnt_ff, cnt_in;

   assign status.full  = (cnt_ff == 2'd2);
   assign status.empty = (cnt_ff == 2'd0);
   assign head_blk     = entry_ff[rp_ff];

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         entry_ff[wp_ff] <= push_blk;
      end
   end

endmodule

/* rtl/core/shae_back.sv */
module shae_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   mode,
   input  shae_pkg::blk_type      head_blk,
   input  shae_pkg::q_status_type q_status,
   output logic                   pop,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [31:0]            out_word,
   output logic [2:0]             out_index,
   output logic                   out_last
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ROUND = 4'b0010,
      ST_ADD   = 4'b0100,
      ST_EMIT  = 4'b1000
   } bstate_type;

   bstate_type  state_ff, state_in;
   logic [31:0] hash_ff [8];
   logic [31:0] hash_in [8];
   logic [31:0] v_ff [8];
   logic [31:0] v_in [8];
   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [5:0]  round_ff, round_in;
   logic        final_ff, final_in;
   logic [2:0]  idx_ff, idx_in;
   logic        ovalid_ff, ovalid_in;
   logic [31:0] oword_ff, oword_in;
   logic [2:0]  oidx_ff, oidx_in;
   logic        olast_ff, olast_in;
   logic [31:0] t1, t2, w_new, chs, mj;
   logic        last_now;

   assign out_valid = ovalid_ff;
   assign out_word  = oword_ff;
   assign out_index = oidx_ff;
   assign out_last  = olast_ff;

   always_comb begin
      state_in  = state_ff;
      hash_in   = hash_ff;
      v_in      = v_ff;
      w_in      = w_ff;
      round_in  = round_ff;
      final_in  = final_ff;
      idx_in    = idx_ff;
      ovalid_in = ovalid_ff && !out_ready;
      oword_in  = oword_ff;
      oidx_in   = oidx_ff;
      olast_in  = olast_ff;
      pop       = 1'b0;
      chs   = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      mj    = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t1    = v_ff[7] + shae_pkg::bsig1(v_ff[4]) + chs + shae_pkg::K_ROUND[round_ff]
              + w_ff[0];
      t2    = shae_pkg::bsig0(v_ff[0]) + mj;
      w_new = shae_pkg::ssig1(w_ff[14]) + w_ff[9] + shae_pkg::ssig0(w_ff[1]) + w_ff[0];
      last_now = (mode == shae_pkg::MODE_224) ? (idx_ff == 3'd6) : (idx_ff == 3'd7);
      case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               pop      = 1'b1;
               final_in = head_blk.final_blk;
               round_in = '0;
               v_in     = hash_ff;
               for (int i = 0; i < 16; i++) begin
                  w_in[i] = head_blk.data[shae_pkg::BLOCK_BITS-1-32*i -: 32];
               end
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            v_in[7] = v_ff[6];
            v_in[6] = v_ff[5];
            v_in[5] = v_ff[4];
            v_in[4] = v_ff[3] + t1;
            v_in[3] = v_ff[2];
            v_in[2] = v_ff[1];
            v_in[1] = v_ff[0];
            v_in[0] = t1 + t2;
            for (int i = 0; i < 15; i++) begin
               w_in[i] = w_ff[i+1];
            end
            w_in[15] = w_new;
            round_in = round_ff + 6'd1;
            if (round_ff == 6'd63) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            for (int i = 0; i < 8; i++) begin
               hash_in[i] = hash_ff[i] + v_ff[i];
            end
            idx_in   = '0;
            state_in = final_ff ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (!ovalid_ff || out_ready) begin
               ovalid_in = 1'b1;
               oword_in  = hash_ff[idx_ff];
               oidx_in   = idx_ff;
               olast_in  = last_now;
               idx_in    = idx_ff + 3'd1;
               if (last_now) begin
                  if (mode == shae_pkg::MODE_224) begin
                     hash_in = shae_pkg::INIT_224;
                  end else begin
                     hash_in = shae_pkg::INIT_256;
                  end
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         hash_ff   <= shae_pkg::INIT_256;
         ovalid_ff <= 1'b0;
         round_ff  <= '0;
         idx_ff    <= '0;
         final_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         hash_ff   <= hash_in;
         ovalid_ff <= ovalid_in;
         round_ff  <= round_in;
         idx_ff    <= idx_in;
         final_ff  <= final_in;
      end
      v_ff     <= v_in;
      w_ff     <= w_in;
      oword_ff <= oword_in;
      oidx_ff  <= oidx_in;
      olast_ff <= olast_in;
   end

endmodule
